>>> sv/mvsc_pkg.sv
// Shared constants, types and codes for the sigma-clipped mean/variance block.
// No dependencies.
package mvsc_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 24;

   localparam int SW     = SAMPLE_BITS;
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int SUM_W  = SW + CNT_W;
   localparam int MAG_W  = SUM_W - 1;
   localparam int SQ_W   = 2 * SW + CNT_W - 2;
   localparam int XSQ_W  = 2 * SW;
   localparam int DM_W   = SW + 1;
   localparam int DSQ_W  = 2 * DM_W;

   localparam int NSIG_W = 16;
   localparam int KK_W   = 2 * NSIG_W;
   localparam int NSIG_FRAC2 = 16;
   localparam int VAR_W  = 47;
   localparam int STATUS_W = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = NSIG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBUST_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_N_SIGMA       = 1'd1;
   localparam logic [NSIG_W-1:0]    N_SIGMA_RESET     = 16'd768;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_VALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLIP_EMPTY = 2'd2;

   localparam int MUL_A_W = (SQ_W > VAR_W) ? SQ_W : VAR_W;
   localparam int MUL_B_W = (MAG_W > KK_W) ? MAG_W : KK_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = PROD_W + 1;
   localparam int DIV_D_W = 2 * CNT_W - 1;
   localparam int ARITH_CNT_W = $clog2(DIV_N_W + 1);
   localparam int CMP_W = (DSQ_W + NSIG_FRAC2 > PROD_W) ? DSQ_W + NSIG_FRAC2 : PROD_W;

   localparam logic [VAR_W-1:0] VAR_MAX = '1;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic               go;
      logic               op;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } arith_cmd_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] value;
   } arith_rsp_type;

   typedef struct packed {
      logic                 live;
      logic                 keep;
      logic signed [SW-1:0] x;
      logic [XSQ_W-1:0]     xsq;
   } clip_out_type;

endpackage

>>> sv/mvsc_store.sv
// Sample store: one write port, one read port, registered read data.
// Depends on mvsc_pkg.
module mvsc_store import mvsc_pkg::*; (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [SW:0]       wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [SW:0]       rdata
);

   logic [SW:0] mem [MAX_SAMPLES];
   logic [SW:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/mvsc_arith.sv
// Shared bit-serial unit: shift-add multiply and restoring divide.
// Depends on mvsc_pkg.
module mvsc_arith import mvsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_cmd_type cmd,
   output arith_rsp_type rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   op_ff, op_in;
   logic [ARITH_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]     a_ff, a_in;
   logic [PROD_W-1:0]      p_ff, p_in;
   logic [DIV_N_W-1:0]     q_ff, q_in;
   logic [DIV_D_W-1:0]     rem_ff, rem_in;
   logic [DIV_D_W-1:0]     den_ff, den_in;
   logic [MUL_A_W:0]       psum;
   logic [DIV_D_W:0]       rsh, rsub;
   logic                   ge;

   always_comb begin
      psum = {1'b0, p_ff[PROD_W-1:MUL_B_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      rsh  = {rem_ff, q_ff[DIV_N_W-1]};
      rsub = rsh - {1'b0, den_ff};
      ge   = (rsh >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (op_ff == OP_DIV) begin
            q_in   = {q_ff[DIV_N_W-2:0], ge};
            rem_in = ge ? rsub[DIV_D_W-1:0] : rsh[DIV_D_W-1:0];
         end else begin
            p_in = {psum, p_ff[MUL_B_W-1:1]};
         end
         if (cnt_ff == ARITH_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.go) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         a_in    = cmd.a;
         p_in    = {{MUL_A_W{1'b0}}, cmd.b};
         q_in    = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = (cmd.op == OP_DIV) ? ARITH_CNT_W'(DIV_N_W) : ARITH_CNT_W'(MUL_B_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = (op_ff == OP_DIV) ? q_ff : DIV_N_W'(p_ff);

endmodule

>>> sv/mvsc_clip.sv
// Clip-pass datapath: distance from mean, squares, band compare.
// Depends on mvsc_pkg; fed from mvsc_store read data.
module mvsc_clip import mvsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_live,
   input  logic [SW:0]          rd_data,
   input  logic signed [SW-1:0] mean,
   input  logic [PROD_W-1:0]    band,
   output clip_out_type         clip
);

   logic                   live1_ff, live2_ff;
   logic                   ok1_ff, ok2_ff;
   logic signed [SW-1:0]   x1_ff, x2_ff;
   logic [DM_W-1:0]        dm_ff;
   logic [SW-1:0]          xm_ff;
   logic [DSQ_W-1:0]       dsq_ff;
   logic [XSQ_W-1:0]       xsq_ff;
   logic signed [SW-1:0]   x_c;
   logic signed [DM_W-1:0] diff_c;
   logic signed [DM_W-1:0] ndiff_c;
   logic signed [SW-1:0]   nx_c;
   logic [CMP_W-1:0]       lhs_c, rhs_c;

   always_comb begin
      x_c     = rd_data[SW-1:0];
      diff_c  = {x_c[SW-1], x_c} - {mean[SW-1], mean};
      ndiff_c = -diff_c;
      nx_c    = -x_c;
      lhs_c   = CMP_W'({dsq_ff, {NSIG_FRAC2{1'b0}}});
      rhs_c   = CMP_W'(band);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live1_ff <= 1'b0;
         live2_ff <= 1'b0;
      end else begin
         live1_ff <= rd_live;
         live2_ff <= live1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff <= rd_data[SW];
      x1_ff  <= x_c;
      dm_ff  <= diff_c[DM_W-1] ? ndiff_c : diff_c;
      xm_ff  <= x_c[SW-1] ? nx_c : x_c;
      ok2_ff <= ok1_ff;
      x2_ff  <= x1_ff;
      dsq_ff <= {{DM_W{1'b0}}, dm_ff} * {{DM_W{1'b0}}, dm_ff};
      xsq_ff <= {{SW{1'b0}}, xm_ff} * {{SW{1'b0}}, xm_ff};
   end

   assign clip.live = live2_ff;
   assign clip.keep = ok2_ff && (lhs_c < rhs_c);
   assign clip.x    = x2_ff;
   assign clip.xsq  = xsq_ff;

endmodule

>>> sv/mean_variance_sigma_clip.sv
// Top level: load sequencer, accumulators and finishing steps.
// Depends on mvsc_pkg, mvsc_store, mvsc_arith, mvsc_clip.
//
// Samples are taken one per cycle while busy is low; each transaction is stored
// while there is room, valid ones are accumulated, and the one carrying
// req_last_sample closes the set. busy then stays high while the result is worked
// out on one bit-serial unit: two multiplies and two divides per pass, each with a
// handoff. With robust mode on, a band multiply, a read of the stored set at one
// entry per cycle and a second finishing pass follow. The result is shown for
// exactly one cycle with rsp_strobe and cannot be held off; busy drops in the next
// cycle.
module mean_variance_sigma_clip import mvsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [SW-1:0]  req_sample,
   input  logic                  req_sample_valid,
   input  logic                  req_last_sample,
   output logic                  rsp_strobe,
   output logic signed [SW-1:0]  rsp_mean_out,
   output logic [VAR_W-1:0]      rsp_variance_out,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SETTLE   = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_MUL_SS   = 4'd3;
   localparam logic [3:0] S_MUL_QN   = 4'd4;
   localparam logic [3:0] S_DIV_MEAN = 4'd5;
   localparam logic [3:0] S_DIV_VAR  = 4'd6;
   localparam logic [3:0] S_MUL_BAND = 4'd7;
   localparam logic [3:0] S_SCAN     = 4'd8;
   localparam logic [3:0] S_DRAIN    = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic                    robust_ff, robust_in;
   logic [NSIG_W-1:0]       nsig_ff, nsig_in;
   logic [CNT_W-1:0]        load_idx_ff, load_idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sqa_ff, sqa_in;
   logic [XSQ_W-1:0]        lsq_ff, lsq_in;
   logic                    lsq_live_ff, lsq_live_in;
   logic                    pass2_ff, pass2_in;
   logic                    wait_ff, wait_in;
   logic                    rd_live_ff;
   logic signed [SW-1:0]    mean_ff, mean_in;
   logic [VAR_W-1:0]        var_ff, var_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [PROD_W-1:0]       ss_ff, ss_in;
   logic [PROD_W-1:0]       diff_ff, diff_in;
   logic [DIV_D_W-1:0]      nn_ff, nn_in;
   logic [KK_W-1:0]         kk_ff, kk_in;
   logic [PROD_W-1:0]       band_ff, band_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic [1:0]              drain_ff, drain_in;

   logic                    accept, in_room, arith_state, rd_en;
   logic signed [SUM_W-1:0] neg_sum;
   logic [MAG_W-1:0]        mag_c;
   logic signed [SW-1:0]    neg_req;
   logic [SW-1:0]           req_mag;
   logic [2*CNT_W-1:0]      nn_full;
   logic [PROD_W-1:0]       res_p;
   logic [SW-1:0]           qm;
   logic [SUM_W-1:0]        clip_x_ext, req_ext;
   logic [SW:0]             rd_data;
   arith_cmd_type           cmd;
   arith_rsp_type           ares;
   clip_out_type            clip;

   mvsc_store u_store (
      .clock (clock),
      .we    (accept && in_room),
      .waddr (load_idx_ff[ADDR_W-1:0]),
      .wdata ({req_sample_valid, req_sample}),
      .re    (rd_en),
      .raddr (scan_ff[ADDR_W-1:0]),
      .rdata (rd_data)
   );

   mvsc_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ares)
   );

   mvsc_clip u_clip (
      .clock   (clock),
      .reset   (reset),
      .rd_live (rd_live_ff),
      .rd_data (rd_data),
      .mean    (mean_ff),
      .band    (band_ff),
      .clip    (clip)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign in_room = (load_idx_ff < CNT_W'(MAX_SAMPLES));
   assign rd_en   = (state_ff == S_SCAN) && (scan_ff != load_idx_ff);

   always_comb begin
      neg_sum    = -sum_ff;
      mag_c      = sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_ff[MAG_W-1:0];
      neg_req    = -req_sample;
      req_mag    = req_sample[SW-1] ? neg_req : req_sample;
      nn_full    = {{CNT_W{1'b0}}, cnt_ff} * {{CNT_W{1'b0}}, cnt_ff};
      res_p      = ares.value[PROD_W-1:0];
      qm         = ares.value[SW-1:0];
      clip_x_ext = {{(SUM_W-SW){clip.x[SW-1]}}, clip.x};
      req_ext    = {{(SUM_W-SW){req_sample[SW-1]}}, req_sample};

      arith_state = (state_ff == S_MUL_SS) || (state_ff == S_MUL_QN) ||
                    (state_ff == S_DIV_MEAN) || (state_ff == S_DIV_VAR) ||
                    (state_ff == S_MUL_BAND);
      cmd.go  = arith_state && !wait_ff;
      cmd.op  = OP_MUL;
      cmd.a   = '0;
      cmd.b   = '0;
      cmd.num = '0;
      cmd.den = '0;
      case (state_ff)
         S_MUL_SS: begin
            cmd.a = MUL_A_W'(mag_c);
            cmd.b = MUL_B_W'(mag_c);
         end
         S_MUL_QN: begin
            cmd.a = MUL_A_W'(sqa_ff);
            cmd.b = MUL_B_W'(cnt_ff);
         end
         S_DIV_MEAN: begin
            cmd.op  = OP_DIV;
            cmd.num = DIV_N_W'(mag_c) + DIV_N_W'(cnt_ff >> 1);
            cmd.den = DIV_D_W'(cnt_ff);
         end
         S_DIV_VAR: begin
            cmd.op  = OP_DIV;
            cmd.num = DIV_N_W'(diff_ff) + DIV_N_W'(nn_ff >> 1);
            cmd.den = nn_ff;
         end
         S_MUL_BAND: begin
            cmd.a = MUL_A_W'(var_ff);
            cmd.b = MUL_B_W'(kk_ff);
         end
         default: begin
            cmd.op = OP_MUL;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      robust_in   = robust_ff;
      nsig_in     = nsig_ff;
      load_idx_in = load_idx_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      sqa_in      = sqa_ff;
      lsq_in      = lsq_ff;
      lsq_live_in = 1'b0;
      pass2_in    = pass2_ff;
      wait_in     = wait_ff;
      mean_in     = mean_ff;
      var_in      = var_ff;
      status_in   = status_ff;
      ss_in       = ss_ff;
      diff_in     = diff_ff;
      nn_in       = nn_ff;
      kk_in       = kk_ff;
      band_in     = band_ff;
      scan_in     = scan_ff;
      drain_in    = drain_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROBUST_ENABLE: robust_in = csr_write_data[0];
            CSR_N_SIGMA:       nsig_in   = csr_write_data;
            default:           robust_in = robust_ff;
         endcase
      end

      if (cmd.go) begin
         wait_in = 1'b1;
      end else if (ares.done) begin
         wait_in = 1'b0;
      end

      // load-side accumulate; the square is registered and added in the next cycle
      if (accept && in_room) begin
         load_idx_in = load_idx_ff + 1'b1;
         if (req_sample_valid) begin
            sum_in      = sum_ff + req_ext;
            cnt_in      = cnt_ff + 1'b1;
            lsq_live_in = 1'b1;
            lsq_in      = {{SW{1'b0}}, req_mag} * {{SW{1'b0}}, req_mag};
         end
      end
      if (lsq_live_ff) begin
         sqa_in = sqa_ff + SQ_W'(lsq_ff);
      end
      if (clip.live && clip.keep) begin
         sum_in = sum_ff + clip_x_ext;
         sqa_in = sqa_ff + SQ_W'(clip.xsq);
         cnt_in = cnt_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && req_last_sample) begin
               pass2_in = 1'b0;
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            nn_in = nn_full[DIV_D_W-1:0];
            kk_in = {{NSIG_W{1'b0}}, nsig_ff} * {{NSIG_W{1'b0}}, nsig_ff};
            if (cnt_ff == '0) begin
               if (pass2_ff) begin
                  status_in = ST_CLIP_EMPTY;
               end else begin
                  status_in = ST_NO_VALID;
                  mean_in   = '0;
                  var_in    = '0;
               end
               state_in = S_OUT;
            end else begin
               state_in = S_MUL_SS;
            end
         end
         S_MUL_SS: begin
            if (ares.done) begin
               ss_in    = res_p;
               state_in = S_MUL_QN;
            end
         end
         S_MUL_QN: begin
            if (ares.done) begin
               diff_in  = (res_p >= ss_ff) ? res_p - ss_ff : ss_ff - res_p;
               state_in = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (ares.done) begin
               mean_in  = sum_ff[SUM_W-1] ? -qm : qm;
               state_in = S_DIV_VAR;
            end
         end
         S_DIV_VAR: begin
            if (ares.done) begin
               var_in = (ares.value > DIV_N_W'(VAR_MAX)) ? VAR_MAX : ares.value[VAR_W-1:0];
               if (!pass2_ff && robust_ff) begin
                  state_in = S_MUL_BAND;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_OUT;
               end
            end
         end
         S_MUL_BAND: begin
            if (ares.done) begin
               band_in  = res_p;
               sum_in   = '0;
               sqa_in   = '0;
               cnt_in   = '0;
               pass2_in = 1'b1;
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff != load_idx_ff) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               drain_in = 2'd3;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drain_ff == 2'd0) begin
               state_in = S_CHECK;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         S_OUT: begin
            sum_in      = '0;
            sqa_in      = '0;
            cnt_in      = '0;
            load_idx_in = '0;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         robust_ff   <= 1'b1;
         nsig_ff     <= N_SIGMA_RESET;
         load_idx_ff <= '0;
         cnt_ff      <= '0;
         sum_ff      <= '0;
         sqa_ff      <= '0;
         lsq_live_ff <= 1'b0;
         pass2_ff    <= 1'b0;
         wait_ff     <= 1'b0;
         rd_live_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         robust_ff   <= robust_in;
         nsig_ff     <= nsig_in;
         load_idx_ff <= load_idx_in;
         cnt_ff      <= cnt_in;
         sum_ff      <= sum_in;
         sqa_ff      <= sqa_in;
         lsq_live_ff <= lsq_live_in;
         pass2_ff    <= pass2_in;
         wait_ff     <= wait_in;
         rd_live_ff  <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      lsq_ff    <= lsq_in;
      mean_ff   <= mean_in;
      var_ff    <= var_in;
      status_ff <= status_in;
      ss_ff     <= ss_in;
      diff_ff   <= diff_in;
      nn_ff     <= nn_in;
      kk_ff     <= kk_in;
      band_ff   <= band_in;
      scan_ff   <= scan_in;
      drain_ff  <= drain_in;
   end

   assign rsp_strobe       = (state_ff == S_OUT);
   assign rsp_mean_out     = mean_ff;
   assign rsp_variance_out = var_ff;
   assign rsp_status       = status_ff;

endmodule

>>> sv/mvsc_checker.sv
// Port-level checks for mean_variance_sigma_clip, attached by bind.
// Depends on mvsc_pkg.
module mvsc_checker import mvsc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_last_sample,
   input logic                  rsp_strobe,
   input logic signed [SW-1:0]  rsp_mean_out,
   input logic [VAR_W-1:0]      rsp_variance_out,
   input logic [STATUS_W-1:0]   rsp_status
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result not a single cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_OK || rsp_status == ST_NO_VALID ||
                      rsp_status == ST_CLIP_EMPTY))
      else $error("bad status");

   a_no_valid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NO_VALID) |->
         (rsp_mean_out == '0 && rsp_variance_out == '0))
      else $error("nonzero result with no valid samples");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_sample) |=> busy)
      else $error("closing transaction did not raise busy");

endmodule

bind mean_variance_sigma_clip mvsc_checker u_mvsc_checker (.*);

>>> bench/mvsc_checker.sv
// Checker for mean_variance_sigma_clip: watches the request, result and CSR ports.
// It predicts each result from the accepted transactions and compares it field by field.
// Depends on mvsc_pkg.
`timescale 1ns / 1ps
module mvsc_scoreboard import mvsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic signed [SW-1:0]  req_sample,
   input  logic                  req_sample_valid,
   input  logic                  req_last_sample,
   input  logic                  rsp_strobe,
   input  logic signed [SW-1:0]  rsp_mean_out,
   input  logic [VAR_W-1:0]      rsp_variance_out,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    failures,
   output int                    pending,
   output int                    results_seen
);

   typedef struct packed {
      logic [SW-1:0]       mean;
      logic [VAR_W-1:0]    variance;
      logic [STATUS_W-1:0] status;
   } stats_type;

   stats_type     stats_queue[$];
   logic          robust_mode;
   logic [15:0]   clip_sigma;
   longint        sample_mem[0:MAX_SAMPLES-1];
   bit            sample_ok[0:MAX_SAMPLES-1];
   longint        running_sum;
   logic [63:0]   running_sq;
   logic [63:0]   count_valid;
   int            fill_index;

   assign pending = stats_queue.size();

   function automatic void fold_stats(input longint s, input logic [63:0] q,
                                      input logic [63:0] n, output longint m_out,
                                      output logic [VAR_W-1:0] v_out);
      logic [127:0] as, m, qn, ss, diff, den, quo;
      as = (s < 0) ? -s : s;
      m = (as + (n >> 1)) / n;
      qn = {64'd0, q} * {64'd0, n};
      ss = as * as;
      diff = (qn < ss) ? ss - qn : qn - ss;
      den = {64'd0, n} * {64'd0, n};
      quo = (diff + (den >> 1)) / den;
      v_out = (quo > VAR_MAX) ? VAR_MAX : quo[VAR_W-1:0];
      m_out = (s < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic stats_type close_set();
      stats_type          r;
      longint             m, s2, dx;
      logic [VAR_W-1:0]   v;
      logic [63:0]        q2, n2, d;
      logic [127:0]       band, ksq;
      m = 0;
      v = '0;
      r.status = ST_NO_VALID;
      if (count_valid != 0) begin
         fold_stats(running_sum, running_sq, count_valid, m, v);
         r.status = ST_OK;
         if (robust_mode) begin
            ksq = clip_sigma * clip_sigma;
            band = {81'd0, v} * ksq;
            s2 = 0;
            q2 = 0;
            n2 = 0;
            for (int i = 0; i < fill_index; i++) begin
               if (sample_ok[i]) begin
                  dx = sample_mem[i] - m;
                  d = ((dx < 0) ? -dx : dx) << 8;
                  if ({64'd0, d} * {64'd0, d} < band) begin
                     s2 += sample_mem[i];
                     q2 += sample_mem[i] * sample_mem[i];
                     n2++;
                  end
               end
            end
            if (n2 == 0) r.status = ST_CLIP_EMPTY;
            else fold_stats(s2, q2, n2, m, v);
         end
      end
      r.mean = m[SW-1:0];
      r.variance = v;
      return r;
   endfunction

   always @(posedge clock) begin
      stats_type e;
      if (reset) begin
         robust_mode <= 1'b1;
         clip_sigma <= N_SIGMA_RESET;
         running_sum = 0;
         running_sq = 0;
         count_valid = 0;
         fill_index = 0;
         failures <= 0;
         results_seen <= 0;
      end else begin
         if (rsp_strobe) begin
            results_seen <= results_seen + 1;
            if (stats_queue.size() == 0) begin
               failures <= failures + 1;
               if (failures < 10) $display("unexpected result transaction");
            end else begin
               e = stats_queue.pop_front();
               if (e.mean !== rsp_mean_out || e.variance !== rsp_variance_out ||
                   e.status !== rsp_status) begin
                  failures <= failures + 1;
                  if (failures < 10)
                     $display("mismatch: mean %h/%h var %h/%h status %0d/%0d (exp/act)",
                              e.mean, rsp_mean_out, e.variance, rsp_variance_out,
                              e.status, rsp_status);
               end
            end
         end
         if (start && !busy) begin
            if (fill_index < MAX_SAMPLES) begin
               sample_mem[fill_index] = req_sample;
               sample_ok[fill_index] = req_sample_valid;
               fill_index++;
               if (req_sample_valid) begin
                  running_sum += req_sample;
                  running_sq += longint'(req_sample) * longint'(req_sample);
                  count_valid++;
               end
            end
            if (req_last_sample) begin
               stats_queue.insert(stats_queue.size(), close_set());
               running_sum = 0;
               running_sq = 0;
               count_valid = 0;
               fill_index = 0;
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_ROBUST_ENABLE) robust_mode <= csr_write_data[0];
            else if (csr_index == CSR_N_SIGMA) clip_sigma <= csr_write_data;
         end
      end
   end

endmodule

>>> bench/mean_variance_sigma_clip_tb.sv
// Testbench top for mean_variance_sigma_clip: clock, reset, stimulus and verdict.
// Depends on mvsc_pkg, the block and mvsc_scoreboard.
`timescale 1ns / 1ps
module mean_variance_sigma_clip_tb import mvsc_pkg::*;;

   localparam int LIMIT = 3000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic signed [SW-1:0]  req_sample = '0;
   logic                  req_sample_valid = 1'b0;
   logic                  req_last_sample = 1'b0;
   logic                  rsp_strobe;
   logic signed [SW-1:0]  rsp_mean_out;
   logic [VAR_W-1:0]      rsp_variance_out;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   int                    failures, pending, results_seen;
   int                    idle_pct = 0;
   int                    cycles = 0;
   int                    items_sent = 0;

   always #1 clock = ~clock;

   mean_variance_sigma_clip uut (.*);

   mvsc_scoreboard checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(input logic [SW-1:0] s, input bit v, input bit l);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_sample <= s;
      req_sample_valid <= v;
      req_last_sample <= l;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SW-1:0] pick_sample(input int center, input int spread);
      int r;
      r = $urandom_range(99);
      if (r < 5) return SW'($urandom);
      if (r < 8) return ($urandom_range(1) != 0) ? 24'h7FFFFF : 24'h800000;
      if (r < 15) return SW'(center + int'($urandom_range(8 * spread)) - 4 * spread);
      return SW'(center + int'($urandom_range(spread)) - spread / 2);
   endfunction

   task automatic random_set(input int len);
      int center, spread;
      center = int'($urandom) >>> 8;
      spread = 1 << $urandom_range(0, 16);
      for (int i = 0; i < len; i++)
         send_item(pick_sample(center, spread), $urandom_range(99) < 85, i == len - 1);
   endtask

   function automatic logic [15:0] pick_sigma();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd256;
         3: return 16'd768;
         default: return 16'($urandom_range(1, 1024));
      endcase
   endfunction

   initial begin
      int len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, single sample, no valid, flat set, band edges
      send_item(24'h7FFFFF, 1'b1, 1'b0);
      send_item(24'h800000, 1'b1, 1'b0);
      send_item(24'h000000, 1'b1, 1'b1);
      send_item(24'h123456, 1'b1, 1'b1);
      send_item(24'h7FFFFF, 1'b0, 1'b0);
      send_item(24'h000001, 1'b0, 1'b1);
      for (int i = 0; i < 4; i++) send_item(24'h001000, 1'b1, i == 3);
      for (int i = 0; i < 5; i++)
         send_item(i == 4 ? 24'h400000 : SW'(24'h000100 + i), 1'b1, i == 4);
      write_csr(CSR_N_SIGMA, 16'd0);
      for (int i = 0; i < 3; i++) send_item(SW'(24'h000010 * i), 1'b1, i == 2);
      write_csr(CSR_N_SIGMA, 16'hFFFF);
      for (int i = 0; i < 3; i++) send_item(i == 0 ? 24'h800000 : 24'h7FFFFF, 1'b1, i == 2);
      write_csr(CSR_ROBUST_ENABLE, 16'd0);
      for (int i = 0; i < 3; i++) send_item(SW'(24'hFFF000 + i), i != 1, i == 2);
      write_csr(CSR_ROBUST_ENABLE, 16'd1);
      write_csr(CSR_N_SIGMA, 16'd256);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 7 : (phase == 1) ? 64 : 0;
         for (int n = 0; n < 400; n += len) begin
            if ($urandom_range(7) == 0) begin
               write_csr(CSR_ROBUST_ENABLE, CSR_DATA_W'($urandom_range(3) != 0));
               write_csr(CSR_N_SIGMA, pick_sigma());
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            if ($urandom_range(15) == 0) begin
               for (int i = 0; i < len; i++)
                  send_item(SW'($urandom), $urandom_range(1) != 0,
                            $urandom_range(7) == 0 || i == len - 1);
            end else begin
               random_set(len);
            end
         end
      end

      wait_quiet();
      repeat (700) @(posedge clock);
      $display("covered %0d request transactions and %0d results", items_sent, results_seen);
      $display("with both clip modes, several band widths and sparse valid flags");
      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/mvsc_pkg.sv
sv/mvsc_store.sv
sv/mvsc_arith.sv
sv/mvsc_clip.sv
sv/mean_variance_sigma_clip.sv
sv/mvsc_checker.sv
bench/mvsc_checker.sv
bench/mean_variance_sigma_clip_tb.sv
